// ===== rtl/sapq_pkg.sv =====
// shared types and constants for the sorted agenda priority queue
`default_nettype none
package sapq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int KEY_BITS      = 16;
   localparam int TAG_BITS      = 16;
   localparam int OCC_BITS      = 5;
   localparam int LIMIT_BITS    = 16;
   localparam int TOTAL_BITS    = 16;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(20);

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_POP    = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_POPPED   = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      kind_type            kind;
      logic [KEY_BITS-1:0] difficulty;
      logic [TAG_BITS-1:0] tag;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [KEY_BITS-1:0] out_difficulty;
      logic [TAG_BITS-1:0] out_tag;
      logic [OCC_BITS-1:0] occupancy;
      logic                over_limit;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // load the input register
      logic execute;   // run the held item and load the result register
   } cmd_type;

endpackage
`default_nettype wire

// ===== rtl/sorted_agenda_priority_queue.sv =====
// top level of the sorted agenda priority queue
`default_nettype none
// Stable sorted priority queue of (difficulty, tag) entries kept in a row of
// QUEUE_DEPTH shift cells, least difficulty at the head. An insert item goes
// in behind every stored entry of lower or equal difficulty, so equal keys
// leave in arrival order; a pop item removes the head. Each item yields one
// result item with a status code, the popped entry (zero unless popped), the
// occupancy after the operation and the over-limit flag (saturating count of
// insert items strictly above task_limit, reset 20, written through csr_).
// An insert into a full queue is dropped but still counted. Each item is
// first captured into the input register, then executed in a step in which
// all cells compare against the key and shift in parallel; the next item
// can be captured while a result still waits on rsp_stall, and execution
// waits only until the result register is free. csr_ready is always high;
// write task_limit only while no item is in flight.
module sorted_agenda_priority_queue #(
   parameter int QUEUE_DEPTH = sapq_pkg::DEPTH_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   // item input
   input  wire                              req_valid,
   output logic                             req_stall,
   input  sapq_pkg::req_type                req_item,
   // result output
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output sapq_pkg::rsp_type                rsp_item,
   // task_limit write
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [sapq_pkg::LIMIT_BITS-1:0]   csr_data
);

   sapq_pkg::cmd_type cmd;

   // register write never back-pressures
   assign csr_ready = 1'b1;

   // sequencer: capture, then execute when the result register frees up
   sapq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // sorted cells, counters and result register
   sapq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .csr_we   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .rsp_item (rsp_item)
   );

endmodule
`default_nettype wire

// ===== rtl/sapq_ctrl.sv =====
// sequencer: takes an item, runs it once the result register is free
`default_nettype none
module sapq_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output sapq_pkg::cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EXEC))
      else $error("accepted item did not reach execute state");
   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid_ff)
      else $error("executed item produced no result");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while held");
`endif

endmodule
`default_nettype wire

// ===== rtl/sapq_dpath.sv =====
// datapath: sorted shift cells, counters, limit register, result register
`default_nettype none
module sapq_dpath #(
   parameter int QUEUE_DEPTH = sapq_pkg::DEPTH_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  sapq_pkg::cmd_type                    cmd,
   input  sapq_pkg::req_type                    req_item,
   input  wire                                  csr_we,
   input  wire [sapq_pkg::LIMIT_BITS-1:0]       csr_data,
   output sapq_pkg::rsp_type                    rsp_item
);

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int KB = sapq_pkg::KEY_BITS;
   localparam int TB = sapq_pkg::TAG_BITS;
   localparam int NB = sapq_pkg::TOTAL_BITS;
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(QUEUE_DEPTH);

   sapq_pkg::req_type         req_ff;
   sapq_pkg::rsp_type         rsp_ff, rsp_in;
   logic [KB-1:0]             key_ff [QUEUE_DEPTH];
   logic [KB-1:0]             key_in [QUEUE_DEPTH];
   logic [TB-1:0]             tag_ff [QUEUE_DEPTH];
   logic [TB-1:0]             tag_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]    le;
   logic [CNT_BITS-1:0]       count_ff, count_in;
   logic [NB-1:0]             total_ff, total_in;
   logic [sapq_pkg::LIMIT_BITS-1:0] limit_ff;
   logic                      is_insert, full, empty, do_push, do_pop;

   assign is_insert = (req_ff.kind == sapq_pkg::KIND_INSERT);
   assign full      = (count_ff == FULL_COUNT);
   assign empty     = (count_ff == '0);
   assign do_push   = cmd.execute && is_insert && !full;
   assign do_pop    = cmd.execute && !is_insert && !empty;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
   end

   // each cell compares against the new key; le cells form a prefix
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign le[i] = (CNT_BITS'(i) < count_ff) && (key_ff[i] <= req_ff.difficulty);

      always_comb begin
         key_in[i] = key_ff[i];
         tag_in[i] = tag_ff[i];
         if (do_push && !le[i]) begin
            if (i == 0) begin
               key_in[i] = req_ff.difficulty;
               tag_in[i] = req_ff.tag;
            end else if (le[(i == 0) ? 0 : i-1]) begin
               key_in[i] = req_ff.difficulty;
               tag_in[i] = req_ff.tag;
            end else begin
               key_in[i] = key_ff[(i == 0) ? 0 : i-1];
               tag_in[i] = tag_ff[(i == 0) ? 0 : i-1];
            end
         end else if (do_pop && (i < QUEUE_DEPTH - 1)) begin
            key_in[i] = key_ff[(i < QUEUE_DEPTH - 1) ? i+1 : i];
            tag_in[i] = tag_ff[(i < QUEUE_DEPTH - 1) ? i+1 : i];
         end
      end

      always_ff @(posedge clock) begin
         if (do_push || do_pop) begin
            key_ff[i] <= key_in[i];
            tag_ff[i] <= tag_in[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      if (do_push) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop) begin
         count_in = count_ff - CNT_BITS'(1);
      end
      if (cmd.execute && is_insert && (total_ff != '1)) begin
         total_in = total_ff + NB'(1);
      end
   end

   always_comb begin
      rsp_in.out_difficulty = '0;
      rsp_in.out_tag        = '0;
      rsp_in.occupancy      = sapq_pkg::OCC_BITS'(count_in);
      rsp_in.over_limit     = (total_in > limit_ff);
      if (is_insert) begin
         rsp_in.status = full ? sapq_pkg::STATUS_FULL : sapq_pkg::STATUS_INSERTED;
      end else if (empty) begin
         rsp_in.status = sapq_pkg::STATUS_EMPTY;
      end else begin
         rsp_in.status         = sapq_pkg::STATUS_POPPED;
         rsp_in.out_difficulty = key_ff[0];
         rsp_in.out_tag        = tag_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
         limit_ff <= sapq_pkg::LIMIT_RESET;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
         if (csr_we) begin
            limit_ff <= csr_data;
         end
      end
   end

   assign rsp_item = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond queue depth");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> (count_ff == $past(count_ff) - CNT_BITS'(1)))
      else $error("pop did not remove exactly one entry");
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && is_insert && full) |=> (count_ff == FULL_COUNT))
      else $error("dropped insert changed the queue");
   a_head_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff > CNT_BITS'(1)) |-> (key_ff[0] <= key_ff[1]))
      else $error("head entries out of order");
`endif

endmodule
`default_nettype wire
